[src/albs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// albs_pkg
// Shared types and constants for the LED bit serializer: transaction
// payloads, queued operation record, register indexes and reset values.
// ----------------------------------------------------------------------------
package albs_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 20;
    localparam int QUEUE_DEPTH_DEF      = 2;

    localparam int BYTE_W      = 8;
    localparam int BITS_LEFT_W = 4;
    localparam int SHORT_LEN_W = 16;
    localparam int LATCH_LEN_W = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    localparam logic [BITS_LEFT_W-1:0] BITS_PER_BYTE = 4'd8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LATCH     = 3'd4;

    // register reset values
    localparam logic [SHORT_LEN_W-1:0] ZERO_HIGH_RST = 16'd56;
    localparam logic [SHORT_LEN_W-1:0] ZERO_LOW_RST  = 16'd144;
    localparam logic [SHORT_LEN_W-1:0] ONE_HIGH_RST  = 16'd144;
    localparam logic [SHORT_LEN_W-1:0] ONE_LOW_RST   = 16'd56;
    localparam logic [LATCH_LEN_W-1:0] LATCH_RST     = 20'd48000;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_frame;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic ready_res;
        logic latching;
        logic overrun;
    } result_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_frame;
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_LATCH = 4'b1000
    } phase_t;

endpackage : albs_pkg
`default_nettype wire

[src/addressable_led_bit_serializer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// addressable_led_bit_serializer
// Single-wire LED data serializer, MSB first, with per-bit high/low timing,
// frame latch period and overrun flagging of bytes loaded while busy.
// ----------------------------------------------------------------------------
//  channel | signals                            | transaction when
//  --------+------------------------------------+---------------------------
//  item    | item_valid, item_stall, item_data  | valid && !stall
//  result  | result_valid, result_stall,        | valid && !stall
//          | result_data                        |
//  config  | cfg_we, cfg_index, cfg_data        | cfg_we
//
//  One item per clock while result_stall is low; each result passes through the
//  operation queue write, then the engine's result register.
//  Tick counter is TICK_COUNT_WIDTH bits; phase lengths clamp to its range.
//  Reset loads the timing registers with their defaults and leaves the line idle.
//  result_stall holds the result register; the queue then fills and raises
//  item_stall after QUEUE_DEPTH further items.
// ----------------------------------------------------------------------------
module addressable_led_bit_serializer #(
    parameter int TICK_COUNT_WIDTH = albs_pkg::TICK_COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH      = albs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [albs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [albs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  albs_pkg::item_t                       item_data,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output albs_pkg::result_t                     result_data
);
    import albs_pkg::*;

    logic q_full;
    logic q_push;
    op_t  q_push_op;
    logic q_valid;
    logic q_pop;
    op_t  q_pop_op;

    albs_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (q_push_op)
    );

    albs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_push_op),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_op    (q_pop_op)
    );

    albs_back #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op_valid     (q_valid),
        .op           (q_pop_op),
        .op_pop       (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule : addressable_led_bit_serializer
`default_nettype wire

[src/albs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// albs_front
// Input side: accepts item transactions, decodes them into load or tick
// operations and pushes them into the operation queue.
// ----------------------------------------------------------------------------
module albs_front (
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  albs_pkg::item_t      item_data,
    input  wire logic            q_full,
    output logic                 q_push,
    output albs_pkg::op_t        q_op
);
    import albs_pkg::*;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    always_comb
    begin
        q_op.byte_value   = item_data.byte_value;
        q_op.end_of_frame = item_data.end_of_frame;
        case (item_data.cmd)
            1'b1:    q_op.kind = OP_TICK;
            default: q_op.kind = OP_LOAD;
        endcase
    end

endmodule : albs_front
`default_nettype wire

[src/albs_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// albs_queue
// Short FIFO of decoded operations between the front and the back end.
// ----------------------------------------------------------------------------
module albs_queue #(
    parameter int DEPTH = albs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  albs_pkg::op_t  push_op,
    output logic           full,
    output logic           pop_valid,
    input  wire logic      pop,
    output albs_pkg::op_t  pop_op
);
    import albs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_op    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule : albs_queue
`default_nettype wire

[src/albs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// albs_back
// Serializer engine: timing registers, phase sequencer with tick counter,
// and the result output register.
// ----------------------------------------------------------------------------
module albs_back #(
    parameter int TICK_COUNT_WIDTH = albs_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [albs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [albs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             op_valid,
    input  albs_pkg::op_t                         op,
    output logic                                  op_pop,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output albs_pkg::result_t                     result_data
);
    import albs_pkg::*;

    localparam int TCW = TICK_COUNT_WIDTH;
    // compare width: holds elapsed + 1 and any register length
    localparam int CW  = (TCW + 1 > LATCH_LEN_W + 1) ? TCW + 1 : LATCH_LEN_W + 1;
    localparam logic [CW-1:0] CMAX = CW'({TCW{1'b1}});

    logic [SHORT_LEN_W-1:0] zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [LATCH_LEN_W-1:0] latch_reg;

    phase_t                 phase_reg, phase_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic [BITS_LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic [TCW-1:0]         elapsed_reg, elapsed_next;
    logic                   frame_end_reg, frame_end_next;

    logic                   result_valid_reg;
    result_t                result_data_reg, result_next;

    logic [LATCH_LEN_W-1:0] len_sel;
    logic [CW-1:0]          len_ext, len_lim, count_inc;
    logic                   done;
    logic                   overrun;
    logic                   bit_one;

    // ---------------- timing registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
            latch_reg     <= LATCH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_HIGH: zero_high_reg <= cfg_data[SHORT_LEN_W-1:0];
                REG_ZERO_LOW:  zero_low_reg  <= cfg_data[SHORT_LEN_W-1:0];
                REG_ONE_HIGH:  one_high_reg  <= cfg_data[SHORT_LEN_W-1:0];
                REG_ONE_LOW:   one_low_reg   <= cfg_data[SHORT_LEN_W-1:0];
                REG_LATCH:     latch_reg     <= cfg_data[LATCH_LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- phase length and counter ----------------
    assign bit_one = shift_reg[BYTE_W-1];

    always_comb
    begin
        case (phase_reg)
            PH_HIGH:  len_sel = LATCH_LEN_W'(bit_one ? one_high_reg : zero_high_reg);
            PH_LOW:   len_sel = LATCH_LEN_W'(bit_one ? one_low_reg : zero_low_reg);
            PH_LATCH: len_sel = latch_reg;
            default:  len_sel = '0;
        endcase
    end

    // a zero length ends on the first tick; long lengths clamp to counter range
    assign len_ext   = CW'(len_sel);
    assign len_lim   = (len_ext > CMAX) ? CMAX : len_ext;
    assign count_inc = CW'(elapsed_reg) + CW'(1);
    assign done      = (count_inc >= len_lim);

    assign op_pop = op_valid && (!result_valid_reg || !result_stall);

    // ---------------- sequencer ----------------
    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        elapsed_next   = elapsed_reg;
        frame_end_next = frame_end_reg;
        overrun        = 1'b0;

        if (op_pop)
        begin
            case (op.kind)
                OP_LOAD:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        shift_next     = op.byte_value;
                        bits_left_next = BITS_PER_BYTE;
                        frame_end_next = op.end_of_frame;
                        phase_next     = PH_HIGH;
                        elapsed_next   = '0;
                    end
                    else
                    begin
                        overrun = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        elapsed_next = done ? '0 : count_inc[TCW-1:0];
                    end
                    case (phase_reg)
                        PH_HIGH:
                        begin
                            if (done)
                            begin
                                phase_next = PH_LOW;
                            end
                        end
                        PH_LOW:
                        begin
                            if (done)
                            begin
                                shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                                bits_left_next = bits_left_reg - 1'b1;
                                if (bits_left_next != '0)
                                begin
                                    phase_next = PH_HIGH;
                                end
                                else if (frame_end_reg)
                                begin
                                    phase_next = PH_LATCH;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_LATCH:
                        begin
                            if (done)
                            begin
                                phase_next     = PH_IDLE;
                                frame_end_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        result_next.line_level = (phase_next == PH_HIGH);
        result_next.ready_res  = (phase_next == PH_IDLE);
        result_next.latching   = (phase_next == PH_LATCH);
        result_next.overrun    = overrun;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            shift_reg        <= '0;
            bits_left_reg    <= '0;
            elapsed_reg      <= '0;
            frame_end_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            elapsed_reg   <= elapsed_next;
            frame_end_reg <= frame_end_next;
            if (op_pop)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            result_data_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // ---------------- assertions ----------------
    a_idle_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (elapsed_reg == '0))
        else $error("tick counter not clear while idle");

    a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW)
            |-> (bits_left_reg != '0 && bits_left_reg <= BITS_PER_BYTE))
        else $error("bit count out of range during a bit");

    a_latch_needs_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LATCH) |-> frame_end_reg)
        else $error("latch phase without end of frame");

    a_tick_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (op_pop && op.kind == OP_TICK) |=> !result_data_reg.overrun)
        else $error("overrun flagged on a tick transaction");

    a_busy_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (op_pop && op.kind == OP_LOAD && phase_reg != PH_IDLE)
            |=> ($stable(shift_reg) && $stable(phase_reg)))
        else $error("dropped byte changed the serializer state");

endmodule : albs_back
`default_nettype wire

[dv/tb_addressable_led_bit_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_addressable_led_bit_serializer
// Self-checking bench for the LED bit serializer. Byte loads and ticks go in
// with random gaps, and results come out under random stalls. A line-state
// predictor tracks every accepted transaction, and each result is compared
// in order against it. Timing registers change only while traffic is drained.
// ----------------------------------------------------------------------------
module tb_addressable_led_bit_serializer;
    import albs_pkg::*;

    localparam int CNT_W = TICK_COUNT_WIDTH_DEF;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
    localparam int TOTAL_ITEMS = 1900;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item_data    = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result_data;

    addressable_led_bit_serializer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of timing registers and serializer state
    logic [SHORT_LEN_W-1:0] len_zero_hi;
    logic [SHORT_LEN_W-1:0] len_zero_lo;
    logic [SHORT_LEN_W-1:0] len_one_hi;
    logic [SHORT_LEN_W-1:0] len_one_lo;
    logic [LATCH_LEN_W-1:0] len_latch;
    logic [BYTE_W-1:0]      tx_byte;
    logic [BITS_LEFT_W-1:0] tx_bits;
    phase_t                 tx_phase;
    logic [CNT_W-1:0]       tx_count;
    logic                   tx_eof;

    result_t pending_line_states[$];

    int  n_errors  = 0;
    int  n_items   = 0;
    int  n_loads   = 0;
    int  n_dropped = 0;
    int  n_frames  = 0;
    int  n_checked = 0;
    int  n_cfg     = 0;
    int  stall_left = 0;
    bit  quiet     = 1'b0;   // no sender gaps, no result stalls

    // Advances the phase counter; true once the phase has run its length.
    function automatic bit phase_expired(input longint unsigned len);
        longint unsigned nxt;
        if (len > CNT_MAX)
            len = CNT_MAX;
        nxt = longint'(tx_count) + 1;
        if (nxt >= len)
        begin
            tx_count = '0;
            return 1'b1;
        end
        tx_count = nxt[CNT_W-1:0];
        return 1'b0;
    endfunction

    function automatic result_t predict_line_state(input item_t it);
        result_t r;
        logic    one_bit;
        r       = '0;
        one_bit = tx_byte[BYTE_W-1];
        if (it.cmd == OP_LOAD)
        begin
            if (tx_phase == PH_IDLE)
            begin
                tx_byte  = it.byte_value;
                tx_bits  = BITS_PER_BYTE;
                tx_eof   = it.end_of_frame;
                tx_phase = PH_HIGH;
                tx_count = '0;
            end
            else
                r.overrun = 1'b1;
        end
        else
        begin
            case (tx_phase)
                PH_HIGH:
                    if (phase_expired(64'(one_bit ? len_one_hi : len_zero_hi)))
                        tx_phase = PH_LOW;
                PH_LOW:
                    if (phase_expired(64'(one_bit ? len_one_lo : len_zero_lo)))
                    begin
                        tx_byte = tx_byte << 1;
                        tx_bits = tx_bits - 1'b1;
                        if (tx_bits == '0)
                            tx_phase = tx_eof ? PH_LATCH : PH_IDLE;
                        else
                            tx_phase = PH_HIGH;
                    end
                PH_LATCH:
                    if (phase_expired(64'(len_latch)))
                    begin
                        tx_phase = PH_IDLE;
                        tx_eof   = 1'b0;
                        n_frames++;
                    end
                default: ;
            endcase
        end
        r.line_level = (tx_phase == PH_HIGH);
        r.ready_res  = (tx_phase == PH_IDLE);
        r.latching   = (tx_phase == PH_LATCH);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void check_bit(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            n_errors++;
        end
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 20)
        begin
            stall_left   <= pick_gap();
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_line_states.size() == 0)
            begin
                $error("result with no transaction pending: %b", result_data);
                n_errors++;
            end
            else
            begin
                want = pending_line_states.pop_front();
                check_bit("line_level", want.line_level, result_data.line_level);
                check_bit("ready_res", want.ready_res, result_data.ready_res);
                check_bit("latching", want.latching, result_data.latching);
                check_bit("overrun", want.overrun, result_data.overrun);
                n_checked++;
            end
        end
    end

    // Leaves valid high after acceptance; the next call keeps or drops it.
    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        do @(posedge clk); while (item_stall);
        pending_line_states.push_back(predict_line_state(it));
        n_items++;
    endtask

    task automatic send_load(input logic [BYTE_W-1:0] value, input logic eof);
        item_t it;
        it.cmd          = OP_LOAD;
        it.byte_value   = value;
        it.end_of_frame = eof;
        if (tx_phase != PH_IDLE)
            n_dropped++;
        n_loads++;
        send_item(it);
    endtask

    // payload fields are don't-care on a tick, so keep them random
    task automatic send_tick();
        item_t it;
        it.cmd          = OP_TICK;
        it.byte_value   = BYTE_W'($urandom_range(0, 255));
        it.end_of_frame = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic run_until_idle(input int noise_pct);
        while (tx_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_load(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_tick();
        end
    endtask

    task automatic wait_results_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_line_states.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_ZERO_HIGH: len_zero_hi = val[SHORT_LEN_W-1:0];
            REG_ZERO_LOW:  len_zero_lo = val[SHORT_LEN_W-1:0];
            REG_ONE_HIGH:  len_one_hi  = val[SHORT_LEN_W-1:0];
            REG_ONE_LOW:   len_one_lo  = val[SHORT_LEN_W-1:0];
            REG_LATCH:     len_latch   = val[LATCH_LEN_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
        n_cfg++;
    endtask

    task automatic set_timing(input logic [SHORT_LEN_W-1:0] zh, input logic [SHORT_LEN_W-1:0] zl,
                              input logic [SHORT_LEN_W-1:0] oh, input logic [SHORT_LEN_W-1:0] ol,
                              input logic [LATCH_LEN_W-1:0] lat);
        wait_results_drained();
        write_reg(REG_ZERO_HIGH, CFG_DATA_W'(zh));
        write_reg(REG_ZERO_LOW, CFG_DATA_W'(zl));
        write_reg(REG_ONE_HIGH, CFG_DATA_W'(oh));
        write_reg(REG_ONE_LOW, CFG_DATA_W'(ol));
        write_reg(REG_LATCH, CFG_DATA_W'(lat));
    endtask

    function automatic logic [SHORT_LEN_W-1:0] rand_bit_len();
        if ($urandom_range(0, 4) == 0)
            return SHORT_LEN_W'($urandom_range(5, 16));
        return SHORT_LEN_W'($urandom_range(0, 4));
    endfunction

    // one and zero bit at reset timing, then part of the reset-length latch
    task automatic test_reset_timing();
        send_tick();
        send_tick();
        send_load(8'hA5, 1'b1);
        while (tx_bits > BITS_LEFT_W'(6))
            send_tick();
        wait_results_drained();
        write_reg(REG_ZERO_HIGH, CFG_DATA_W'(16'd2));
        write_reg(REG_ZERO_LOW, CFG_DATA_W'(16'd3));
        write_reg(REG_ONE_HIGH, CFG_DATA_W'(16'd3));
        write_reg(REG_ONE_LOW, CFG_DATA_W'(16'd2));
        while (tx_phase != PH_LATCH)
            send_tick();
        repeat (40) send_tick();
        set_timing(16'd2, 16'd3, 16'd3, 16'd2, 20'd6);
        run_until_idle(0);
    endtask

    // zero lengths act as one tick; overrun in every busy phase
    task automatic test_zero_lengths();
        set_timing('0, '0, '0, '0, '0);
        send_load(8'hFF, 1'b1);
        send_load(8'h00, 1'b0);
        send_tick();
        send_load(8'h00, 1'b1);
        while (tx_phase != PH_LATCH)
            send_tick();
        send_load(8'hAA, 1'b0);
        send_tick();
        send_tick();
        wait_results_drained();
        // indexes past the last register must be ignored
        for (int i = REG_LATCH + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), '1);
        send_load(8'h00, 1'b0);
        run_until_idle(0);
    endtask

    task automatic test_max_lengths();
        set_timing(16'd1, 16'd1, '1, '1, '1);
        send_load(8'h00, 1'b0);
        run_until_idle(0);
        set_timing('1, '1, 16'd1, 16'd1, '1);
        send_load(8'hFF, 1'b0);
        run_until_idle(0);
    endtask

    // sender holds off mid-byte until every result is back
    task automatic test_sender_pause();
        set_timing(16'd3, 16'd2, 16'd4, 16'd1, 20'd5);
        send_load(8'hC3, 1'b1);
        repeat (3) send_tick();
        wait_results_drained();
        run_until_idle(0);
    endtask

    task automatic test_random_traffic();
        int seqs;
        int kind;
        seqs    = 0;
        while (n_items < TOTAL_ITEMS)
        begin
            if (seqs % 6 == 0)
            begin
                quiet = 1'b0;
                set_timing(rand_bit_len(), rand_bit_len(), rand_bit_len(), rand_bit_len(),
                           ($urandom_range(0, 9) == 0) ? LATCH_LEN_W'($urandom_range(100, 400))
                                                        : LATCH_LEN_W'($urandom_range(0, 24)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_INDEX_W'($urandom_range(REG_LATCH + 1, (1 << CFG_INDEX_W) - 1)),
                              CFG_DATA_W'($urandom));
            end
            quiet = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 75)
            begin
                send_load(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 35);
                run_until_idle($urandom_range(0, 1) ? 0 : 8);
            end
            else if (kind < 85)
                repeat ($urandom_range(1, 4)) send_tick();
            else if (kind < 93)
            begin
                send_load(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 3))
                    send_load(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                run_until_idle(20);
            end
            else
            begin
                send_load(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 4)) send_tick();
                wait_results_drained();
                run_until_idle(0);
            end
            seqs++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        len_zero_hi = ZERO_HIGH_RST;
        len_zero_lo = ZERO_LOW_RST;
        len_one_hi  = ONE_HIGH_RST;
        len_one_lo  = ONE_LOW_RST;
        len_latch   = LATCH_RST;
        tx_byte     = '0;
        tx_bits     = '0;
        tx_phase    = PH_IDLE;
        tx_count    = '0;
        tx_eof      = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_zero_lengths();
        test_max_lengths();
        test_sender_pause();
        test_random_traffic();

        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d transactions: %0d byte loads, %0d dropped while busy, %0d frames latched",
                 n_items, n_loads, n_dropped, n_frames);
        $display("Compared %0d results in order over %0d register writes (reset, zero, max, random)",
                 n_checked, n_cfg);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(100_000_000);
        $display("Timeout with %0d results outstanding", pending_line_states.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
src/albs_pkg.sv
src/albs_front.sv
src/albs_queue.sv
src/albs_back.sv
src/addressable_led_bit_serializer.sv
dv/tb_addressable_led_bit_serializer.sv
